/* rtl/core/r2fft_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2fft_pkg
// shared sizes, request codes, sequencer states, command bundle and twiddle rom
// ----------------------------------------------------------------------------
package r2fft_pkg;

  localparam int POINTS       = 512;
  localparam int LOG2_POINTS  = $clog2(POINTS);
  localparam int SAMPLE_BITS  = 16;
  localparam int TWIDDLE_BITS = 16;
  localparam int WORK_BITS    = SAMPLE_BITS + LOG2_POINTS;
  localparam int PROD_BITS    = WORK_BITS + TWIDDLE_BITS;
  localparam int SQ_BITS      = 2 * WORK_BITS;
  localparam int ROOT_BITS    = WORK_BITS;
  localparam int TW_DEPTH     = POINTS / 2;
  localparam int TW_IDX_BITS  = LOG2_POINTS - 1;
  localparam int BFLY_BITS    = LOG2_POINTS - 1;
  localparam int STAGE_BITS   = $clog2(LOG2_POINTS);

  // fixed field widths of the stream words
  localparam int REQ_BITS  = 2;
  localparam int IDX_BITS  = 9;
  localparam int IN_BITS   = 16;
  localparam int OUT_BITS  = 25;
  localparam int IN_TDATA_BITS  = ((IDX_BITS + 2 * IN_BITS) + 7) / 8 * 8;
  localparam int OUT_FIELD_BITS = 3 * OUT_BITS + IDX_BITS;
  localparam int OUT_TDATA_BITS = (OUT_FIELD_BITS + 7) / 8 * 8;

  localparam logic [REQ_BITS-1:0] REQ_LOAD = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_RUN  = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_READ = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_BF_RD,
    ST_BF_MUL,
    ST_BF_ADD,
    ST_BF_WRL,
    ST_BF_WRM,
    ST_RD_MEM,
    ST_RD_SQ,
    ST_RD_SUM,
    ST_SQRT,
    ST_RD_OUT
  } r2fft_state_t;

  typedef struct packed {
    logic                  capture;
    logic                  load_wr;
    logic                  bf_sel;
    logic                  prod_en;
    logic                  res_en;
    logic                  wr_l;
    logic                  wr_m;
    logic                  rd_sq;
    logic                  sqrt_start;
    logic                  out_load;
    logic [STAGE_BITS-1:0] stage;
    logic [BFLY_BITS-1:0]  bfly;
  } r2fft_cmd_t;

  typedef struct packed {
    logic sqrt_busy;
  } r2fft_status_t;

  typedef logic signed [TWIDDLE_BITS-1:0] tw_t;
  typedef tw_t tw_rom_t [TW_DEPTH];

  localparam real PI_R = 3.14159265358979323846;

  // round half up to the twiddle grid, saturate 1.0 to the largest code
  function automatic int tw_quant(real x);
    real y;
    int  q;
    int  lim;
    lim = (1 << (TWIDDLE_BITS - 1)) - 1;
    y   = $floor(x * (2.0 ** (TWIDDLE_BITS - 1)) + 0.5);
    q   = int'(y);
    if (q > lim) q = lim;
    return q;
  endfunction

  function automatic tw_rom_t tw_cos_rom();
    tw_rom_t rom;
    real     c;
    for (int k = 0; k < TW_DEPTH; k++) begin
      c = $cos(2.0 * PI_R * k / POINTS);
      rom[k] = (c >= 0.0) ? tw_t'(tw_quant(c)) : tw_t'(-tw_quant(-c));
    end
    return rom;
  endfunction

  function automatic tw_rom_t tw_sin_rom();
    tw_rom_t rom;
    real     s;
    for (int k = 0; k < TW_DEPTH; k++) begin
      s = $sin(2.0 * PI_R * k / POINTS);
      rom[k] = (s >= 0.0) ? tw_t'(tw_quant(s)) : tw_t'(-tw_quant(-s));
    end
    return rom;
  endfunction

endpackage

/* rtl/core/r2fft_isqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2fft_isqrt
// iterative integer square root, two operand bits per cycle
// ----------------------------------------------------------------------------
module r2fft_isqrt import r2fft_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [SQ_BITS-1:0]   operand,
  output logic                 busy,
  output logic [ROOT_BITS-1:0] root
);

  logic               busy_r, busy_nxt;
  logic [SQ_BITS-1:0] rem_r, rem_nxt;
  logic [SQ_BITS-1:0] res_r, res_nxt;
  logic [SQ_BITS-1:0] bit_r, bit_nxt;
  logic [SQ_BITS-1:0] trial;

  assign trial = res_r + bit_r;

  always_comb begin
    busy_nxt = busy_r;
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    if (start) begin
      busy_nxt = 1'b1;
      rem_nxt  = operand;
      res_nxt  = '0;
      bit_nxt  = {2'b01, {(SQ_BITS-2){1'b0}}};
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_nxt = rem_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r == SQ_BITS'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign busy = busy_r;
  assign root = res_r[ROOT_BITS-1:0];

endmodule

/* rtl/core/r2fft_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2fft_dp
// work store, shared butterfly, bin squaring and output word registers
// ----------------------------------------------------------------------------
module r2fft_dp import r2fft_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_wr_data,
  input  logic [IDX_BITS-1:0]         in_index,
  input  logic signed [IN_BITS-1:0]   in_re,
  input  logic signed [IN_BITS-1:0]   in_im,
  input  r2fft_cmd_t                  cmd,
  output r2fft_status_t               status,
  output logic signed [OUT_BITS-1:0]  bin_re,
  output logic signed [OUT_BITS-1:0]  bin_im,
  output logic [OUT_BITS-1:0]         bin_mag,
  output logic [IDX_BITS-1:0]         bin_num
);

  localparam tw_rom_t TW_COS = tw_cos_rom();
  localparam tw_rom_t TW_SIN = tw_sin_rom();

  logic inverse_r;

  logic [IDX_BITS-1:0]           idx_r;
  logic signed [IN_BITS-1:0]     samp_re_r, samp_im_r;

  logic signed [WORK_BITS-1:0]   work_re_r [POINTS];
  logic signed [WORK_BITS-1:0]   work_im_r [POINTS];
  logic signed [WORK_BITS-1:0]   rd_a_re_r, rd_a_im_r, rd_b_re_r, rd_b_im_r;

  logic [BFLY_BITS:0]            one_sh;
  logic [BFLY_BITS-1:0]          lo_mask, lo_part, hi_part;
  logic [LOG2_POINTS-1:0]        addr_l, addr_m, idx_rev;
  logic [STAGE_BITS-1:0]         tw_shift;
  logic [TW_IDX_BITS-1:0]        tw_idx;
  logic [LOG2_POINTS-1:0]        addr_a, addr_b, waddr;
  logic                          we;
  logic signed [WORK_BITS-1:0]   wd_re, wd_im;

  tw_t                           tw_re_r, tw_im_r;
  logic signed [PROD_BITS-1:0]   p_rr_r, p_ii_r, p_ir_r, p_ri_r;
  logic signed [PROD_BITS:0]     tr_full, ti_full, tr_rnd, ti_rnd;
  logic signed [WORK_BITS-1:0]   tr_w, ti_w;
  logic signed [WORK_BITS-1:0]   sum_re_r, sum_im_r, dif_re_r, dif_im_r;

  logic signed [OUT_BITS-1:0]    re_r, im_r;
  logic signed [SQ_BITS-1:0]     sq_re_r, sq_im_r;
  logic [SQ_BITS-1:0]            sq_sum;
  logic [ROOT_BITS-1:0]          root;
  logic                          sqrt_busy;

  logic signed [OUT_BITS-1:0]    bin_re_r, bin_im_r;
  logic [OUT_BITS-1:0]           bin_mag_r;
  logic [IDX_BITS-1:0]           bin_num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inverse_r <= 1'b0;
    end else if (cfg_wr_en) begin
      inverse_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_r     <= in_index;
      samp_re_r <= in_re;
      samp_im_r <= in_im;
    end
  end

  // butterfly pair: insert a zero at the stage bit for the lower leg, a one for the upper
  assign one_sh   = {{BFLY_BITS{1'b0}}, 1'b1} << cmd.stage;
  assign lo_mask  = one_sh[BFLY_BITS-1:0] - {{(BFLY_BITS-1){1'b0}}, 1'b1};
  assign lo_part  = cmd.bfly & lo_mask;
  assign hi_part  = cmd.bfly & ~lo_mask;
  assign addr_l   = {hi_part, 1'b0} | {1'b0, lo_part};
  assign addr_m   = addr_l | one_sh;
  assign tw_shift = STAGE_BITS'(LOG2_POINTS - 1) - cmd.stage;
  assign tw_idx   = TW_IDX_BITS'(lo_part << tw_shift);

  always_comb begin
    for (int b = 0; b < LOG2_POINTS; b++) idx_rev[b] = idx_r[LOG2_POINTS-1-b];
  end

  assign addr_a = cmd.bf_sel ? addr_l : idx_r[LOG2_POINTS-1:0];
  assign addr_b = addr_m;
  assign we     = cmd.load_wr | cmd.wr_l | cmd.wr_m;

  always_comb begin
    waddr = addr_m;
    wd_re = dif_re_r;
    wd_im = dif_im_r;
    if (cmd.load_wr) begin
      waddr = idx_rev;
      wd_re = WORK_BITS'(samp_re_r);
      wd_im = inverse_r ? WORK_BITS'(samp_im_r) : '0;
    end else if (cmd.wr_l) begin
      waddr = addr_l;
      wd_re = sum_re_r;
      wd_im = sum_im_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      work_re_r[waddr] <= wd_re;
      work_im_r[waddr] <= wd_im;
    end
    rd_a_re_r <= work_re_r[addr_a];
    rd_a_im_r <= work_im_r[addr_a];
    rd_b_re_r <= work_re_r[addr_b];
    rd_b_im_r <= work_im_r[addr_b];
  end

  always_ff @(posedge clk) begin
    tw_re_r <= TW_COS[tw_idx];
    tw_im_r <= TW_SIN[tw_idx];
    if (cmd.prod_en) begin
      p_rr_r <= rd_b_re_r * tw_re_r;
      p_ii_r <= rd_b_im_r * tw_im_r;
      p_ir_r <= rd_b_im_r * tw_re_r;
      p_ri_r <= rd_b_re_r * tw_im_r;
    end
  end

  // forward uses the conjugate twiddle
  always_comb begin
    if (inverse_r) begin
      tr_full = {p_rr_r[PROD_BITS-1], p_rr_r} - {p_ii_r[PROD_BITS-1], p_ii_r};
      ti_full = {p_ir_r[PROD_BITS-1], p_ir_r} + {p_ri_r[PROD_BITS-1], p_ri_r};
    end else begin
      tr_full = {p_rr_r[PROD_BITS-1], p_rr_r} + {p_ii_r[PROD_BITS-1], p_ii_r};
      ti_full = {p_ir_r[PROD_BITS-1], p_ir_r} - {p_ri_r[PROD_BITS-1], p_ri_r};
    end
    tr_rnd = tr_full + (PROD_BITS+1)'(1 << (TWIDDLE_BITS - 2));
    ti_rnd = ti_full + (PROD_BITS+1)'(1 << (TWIDDLE_BITS - 2));
    tr_w   = tr_rnd[TWIDDLE_BITS-1 +: WORK_BITS];
    ti_w   = ti_rnd[TWIDDLE_BITS-1 +: WORK_BITS];
  end

  always_ff @(posedge clk) begin
    if (cmd.res_en) begin
      sum_re_r <= rd_a_re_r + tr_w;
      sum_im_r <= rd_a_im_r + ti_w;
      dif_re_r <= rd_a_re_r - tr_w;
      dif_im_r <= rd_a_im_r - ti_w;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_sq) begin
      re_r    <= OUT_BITS'(rd_a_re_r);
      im_r    <= OUT_BITS'(rd_a_im_r);
      sq_re_r <= SQ_BITS'(rd_a_re_r * rd_a_re_r);
      sq_im_r <= SQ_BITS'(rd_a_im_r * rd_a_im_r);
    end
  end

  assign sq_sum = $unsigned(sq_re_r) + $unsigned(sq_im_r);

  r2fft_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.sqrt_start),
    .operand (sq_sum),
    .busy    (sqrt_busy),
    .root    (root)
  );

  assign status.sqrt_busy = sqrt_busy;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      bin_re_r  <= re_r;
      bin_im_r  <= im_r;
      bin_mag_r <= OUT_BITS'(root);
      bin_num_r <= idx_r;
    end
  end

  assign bin_re  = bin_re_r;
  assign bin_im  = bin_im_r;
  assign bin_mag = bin_mag_r;
  assign bin_num = bin_num_r;

endmodule

/* rtl/core/r2fft_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2fft_ctrl
// request sequencer: load, butterfly schedule over all stages, bin read
// ----------------------------------------------------------------------------
module r2fft_ctrl import r2fft_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [REQ_BITS-1:0] in_req,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  output r2fft_cmd_t          cmd,
  input  r2fft_status_t       status
);

  r2fft_state_t          state_r, state_nxt;
  logic [STAGE_BITS-1:0] stage_r, stage_nxt;
  logic [BFLY_BITS-1:0]  bfly_r, bfly_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  accept, last_bfly, out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid & in_ready;
  assign last_bfly = (stage_r == STAGE_BITS'(LOG2_POINTS - 1)) && (&bfly_r);
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_req)
            REQ_LOAD: state_nxt = ST_LOAD;
            REQ_RUN:  state_nxt = ST_BF_RD;
            REQ_READ: state_nxt = ST_RD_MEM;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LOAD:   state_nxt = ST_IDLE;
      ST_BF_RD:  state_nxt = ST_BF_MUL;
      ST_BF_MUL: state_nxt = ST_BF_ADD;
      ST_BF_ADD: state_nxt = ST_BF_WRL;
      ST_BF_WRL: state_nxt = ST_BF_WRM;
      ST_BF_WRM: state_nxt = last_bfly ? ST_IDLE : ST_BF_RD;
      ST_RD_MEM: state_nxt = ST_RD_SQ;
      ST_RD_SQ:  state_nxt = ST_RD_SUM;
      ST_RD_SUM: state_nxt = ST_SQRT;
      ST_SQRT:   state_nxt = status.sqrt_busy ? ST_SQRT : ST_RD_OUT;
      ST_RD_OUT: state_nxt = out_free ? ST_IDLE : ST_RD_OUT;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.stage      = stage_r;
    cmd.bfly       = bfly_r;
    cmd.capture    = accept;
    unique case (state_r)
      ST_IDLE:   ;
      ST_LOAD:   cmd.load_wr = 1'b1;
      ST_BF_RD:  cmd.bf_sel = 1'b1;
      ST_BF_MUL: begin
        cmd.bf_sel  = 1'b1;
        cmd.prod_en = 1'b1;
      end
      ST_BF_ADD: begin
        cmd.bf_sel = 1'b1;
        cmd.res_en = 1'b1;
      end
      ST_BF_WRL: begin
        cmd.bf_sel = 1'b1;
        cmd.wr_l   = 1'b1;
      end
      ST_BF_WRM: begin
        cmd.bf_sel = 1'b1;
        cmd.wr_m   = 1'b1;
      end
      ST_RD_MEM: ;
      ST_RD_SQ:  cmd.rd_sq = 1'b1;
      ST_RD_SUM: cmd.sqrt_start = 1'b1;
      ST_SQRT:   ;
      ST_RD_OUT: cmd.out_load = out_free;
      default:   ;
    endcase
  end

  always_comb begin
    stage_nxt = stage_r;
    bfly_nxt  = bfly_r;
    if (accept && in_req == REQ_RUN) begin
      stage_nxt = '0;
      bfly_nxt  = '0;
    end else if (state_r == ST_BF_WRM) begin
      bfly_nxt = bfly_r + 1'b1;
      if (&bfly_r) stage_nxt = stage_r + 1'b1;
    end
  end

  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      stage_r     <= '0;
      bfly_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stage_r     <= stage_nxt;
      bfly_r      <= bfly_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/core/radix2_fft_ifft_engine_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix2_fft_ifft_engine_top
// 512-point in-place radix-2 dit fft / unscaled ifft with bit-reversed loading
// ----------------------------------------------------------------------------
//
//  port group   dir  word contents
//  in_*         in   tuser: req_type (0 load, 1 run, 2 read); tdata: index, re, im
//  out_*        out  tdata: bin_re, bin_im, bin_magnitude, bin_number
//  cfg_*        in   single write of inverse_mode, no read-back
//
//  load: capture, one store write at the reversed index, then the next word is taken
//  run: read, multiply, add, write lower and write upper per butterfly on the one
//    shared butterfly, 256 x 9 butterflies
//  read: squaring, then the 25-step square root of re^2 + im^2
//  rst_n is synchronous; the work store is not cleared, entries are valid once loaded
//  a finished bin waits in the output register; a new word is taken meanwhile,
//    and only the next bin read stalls on an untaken result
//
module radix2_fft_ifft_engine_top import r2fft_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // bits low to high: point_index[8:0], sample_re[24:9], sample_im[40:25], zero pad
  input  logic [IN_TDATA_BITS-1:0]  in_tdata,
  // bits low to high: req_type[1:0]
  input  logic [REQ_BITS-1:0]       in_tuser,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // bits low to high: bin_re[24:0], bin_im[49:25], bin_magnitude[74:50],
  // bin_number[83:75], zero pad
  output logic [OUT_TDATA_BITS-1:0] out_tdata,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_wr_data
);

  r2fft_cmd_t                 cmd;
  r2fft_status_t              status;
  logic signed [OUT_BITS-1:0] bin_re, bin_im;
  logic [OUT_BITS-1:0]        bin_mag;
  logic [IDX_BITS-1:0]        bin_num;

  // sequencer: handshakes, stage and butterfly counters
  r2fft_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_req    (in_tuser),
    .in_ready  (in_tready),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .cmd       (cmd),
    .status    (status)
  );

  // store, butterfly, magnitude path
  r2fft_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_index    (in_tdata[IDX_BITS-1:0]),
    .in_re       (in_tdata[IDX_BITS +: IN_BITS]),
    .in_im       (in_tdata[IDX_BITS+IN_BITS +: IN_BITS]),
    .cmd         (cmd),
    .status      (status),
    .bin_re      (bin_re),
    .bin_im      (bin_im),
    .bin_mag     (bin_mag),
    .bin_num     (bin_num)
  );

  // pack the result word, first field lowest
  assign out_tdata = {{(OUT_TDATA_BITS-OUT_FIELD_BITS){1'b0}},
                      bin_num, bin_mag, bin_im, bin_re};

endmodule

/* rtl/core/r2fft_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2fft_checker
// port-level checks on the engine, bound to the top level
// ----------------------------------------------------------------------------
module r2fft_checker import r2fft_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic [REQ_BITS-1:0]       in_tuser,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [OUT_TDATA_BITS-1:0] out_tdata
);

  logic signed [OUT_BITS-1:0] chk_re;
  logic [OUT_BITS-1:0]        chk_abs_re, chk_mag;
  logic                       in_acc;

  assign chk_re     = out_tdata[OUT_BITS-1:0];
  assign chk_abs_re = chk_re[OUT_BITS-1] ? OUT_BITS'(-chk_re) : OUT_BITS'(chk_re);
  assign chk_mag    = out_tdata[2*OUT_BITS +: OUT_BITS];
  assign in_acc     = in_tvalid & in_tready;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // only a bin read produces a result
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser != REQ_READ && !out_tvalid |=> !out_tvalid)
    else $error("result word without a read");

  // one request at a time
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tuser == REQ_LOAD || in_tuser == REQ_RUN || in_tuser == REQ_READ)
      |=> !in_tready)
    else $error("second word taken while busy");

  // magnitude is never below the real part
  a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> chk_mag >= chk_abs_re)
    else $error("magnitude below real part");

endmodule

bind radix2_fft_ifft_engine_top r2fft_checker u_r2fft_checker (.*);
